// ===== rtl/clt_pkg.sv =====
// shared constants, types and helper functions of the console line tokenizer
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

	localparam int LINE_CHARS = 64;
	localparam int ADDR_W     = $clog2(LINE_CHARS);
	localparam int FILL_W     = $clog2(LINE_CHARS + 1);
	localparam int CFG_IDX_W  = 2;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] COMMA_CHAR = 8'h2c;
	localparam logic [7:0] COLON_CHAR = 8'h3a;
	localparam logic [7:0] SLASH_CHAR = 8'h2f;

	localparam logic [7:0] DELETE_RST = 8'd127;
	localparam logic [7:0] END_RST    = 8'd13;
	localparam logic [7:0] QUOTE_RST  = 8'd34;

	localparam logic [CFG_IDX_W-1:0] REG_DELETE_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CODE  = 2'd2;

	typedef enum logic [2:0] {
		CLS_DELIM  = 3'd0,
		CLS_QUOTE  = 3'd1,
		CLS_DELETE = 3'd2,
		CLS_END    = 3'd3,
		CLS_OTHER  = 3'd4
	} cls_t;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_BETWEEN = 2'd0;
	localparam mode_t MODE_QUOTED  = 2'd1;
	localparam mode_t MODE_WORD    = 2'd2;
	localparam mode_t MODE_AFTER   = 2'd3;

	// next mode, indexed by current mode, one row per class except end, which always returns to between
	localparam mode_t NM_DELIM [4] = '{MODE_BETWEEN, MODE_QUOTED, MODE_AFTER, MODE_AFTER};
	localparam mode_t NM_QUOTE [4] = '{MODE_QUOTED, MODE_AFTER, MODE_QUOTED, MODE_QUOTED};
	localparam mode_t NM_DELETE [4] = '{MODE_BETWEEN, MODE_QUOTED, MODE_WORD, MODE_AFTER};
	localparam mode_t NM_OTHER [4] = '{MODE_WORD, MODE_QUOTED, MODE_WORD, MODE_WORD};

	typedef struct packed {
		logic take_in;
		logic step_mode;
		logic wr_en;
		logic wr_space;
		logic del;
		logic scan_start;
		logic rd;
		logic proc;
		logic flush;
		logic line_done;
	} cmd_t;

	typedef struct packed {
		cls_t  cls;
		mode_t mode;
		logic  scan_end;
		logic  proc_stall;
		logic  flush_wait;
	} sts_t;

	// delimiters win over the programmable codes, then quote, delete, end
	function automatic cls_t classify(input logic [7:0] c, input logic [7:0] quote_code,
			input logic [7:0] delete_code, input logic [7:0] end_code);
		cls_t cls;
		if (c == COMMA_CHAR || c == SPACE_CHAR || c == COLON_CHAR || c == SLASH_CHAR) begin
			cls = CLS_DELIM;
		end else if (c == quote_code) begin
			cls = CLS_QUOTE;
		end else if (c == delete_code) begin
			cls = CLS_DELETE;
		end else if (c == end_code) begin
			cls = CLS_END;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

	function automatic mode_t next_mode(input cls_t cls, input mode_t mode);
		mode_t nm;
		case (cls)
			CLS_DELIM:  nm = NM_DELIM[mode];
			CLS_QUOTE:  nm = NM_QUOTE[mode];
			CLS_DELETE: nm = NM_DELETE[mode];
			CLS_END:    nm = MODE_BETWEEN;
			CLS_OTHER:  nm = NM_OTHER[mode];
			default:    nm = MODE_BETWEEN;
		endcase
		return nm;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/clt_char_if.sv =====
// input character channel
`timescale 1ns / 1ps
`default_nettype none

interface clt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/clt_tok_if.sv =====
// token character output channel
`timescale 1ns / 1ps
`default_nettype none

interface clt_tok_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic       token_last;
	logic       line_last;

	modport source (output valid, output token_char, output token_last, output line_last,
		input ready);
	modport sink (input valid, input token_char, input token_last, input line_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/clt_cfg_if.sv =====
// configuration register write channel
`timescale 1ns / 1ps
`default_nettype none

interface clt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [clt_pkg::CFG_IDX_W-1:0]  index;
	logic [7:0]                     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/console_line_tokenizer_unit.sv =====
// top level of the console line tokenizer
`timescale 1ns / 1ps
`default_nettype none

// Takes one console character per input transaction and edits a 64-character
// line store; on the end-of-line code the stored line is split into tokens and
// sent out one character per output transaction, the last character of each
// token marked by token_last and the last of the line by line_last. An ordinary
// character, delimiter or delete passes through a take and an execute step, a
// quote that also stores a space through one more write step. An end-of-line scans
// the stored line, holding while the output is stalled: the line store has one
// registered read port, and each read is followed by a classify-and-emit step.
// No input is taken during line emission. The configuration port is always ready.

module console_line_tokenizer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	clt_char_if.sink  char_in,
	clt_tok_if.source tok_out,
	clt_cfg_if.sink   cfg
);

	clt_pkg::cmd_t cmd;
	clt_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	clt_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_in.valid),
		.in_ready (char_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	clt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_in.char_code),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_wdata (cfg.wdata),
		.out_ready (tok_out.ready),
		.out_valid (tok_out.valid),
		.out_char  (tok_out.token_char),
		.out_tlast (tok_out.token_last),
		.out_llast (tok_out.line_last)
	);

endmodule

`default_nettype wire

// ===== rtl/clt_datapath.sv =====
// datapath: code registers, line store, token scanner and output register
`timescale 1ns / 1ps
`default_nettype none

module clt_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire clt_pkg::cmd_t                 cmd,
	output      clt_pkg::sts_t                 sts,
	input  wire logic [7:0]                    char_code,
	input  wire logic                          cfg_valid,
	input  wire logic [clt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_wdata,
	input  wire logic                          out_ready,
	output      logic                          out_valid,
	output      logic [7:0]                    out_char,
	output      logic                          out_tlast,
	output      logic                          out_llast
);

	logic [7:0]                  char_q;
	logic [7:0]                  delete_q;
	logic [7:0]                  end_q;
	logic [7:0]                  quote_q;
	clt_pkg::mode_t              mode_q;
	logic [clt_pkg::FILL_W-1:0]  fill_q;
	logic [clt_pkg::FILL_W-1:0]  idx_q;
	logic [7:0]                  rdata_q;
	logic [7:0]                  pend_char_q;
	logic                        pend_valid_q;
	logic                        pend_tlast_q;
	logic                        open_q;
	logic                        quoted_q;
	logic                        ovalid_q;
	logic [7:0]                  ochar_q;
	logic                        otlast_q;
	logic                        ollast_q;

	logic [7:0] mem [clt_pkg::LINE_CHARS];

	clt_pkg::cls_t cls_in;
	clt_pkg::cls_t cls_rd;
	logic          emit;
	logic          close;
	logic          quoted_nxt;
	logic          can_push;
	logic          proc_stall;
	logic          proc_go;
	logic          push_proc;
	logic          push_flush;
	logic          has_room;
	logic          we;
	logic [7:0]    wdata;

	assign cls_in = clt_pkg::classify(char_q, quote_q, delete_q, end_q);
	assign cls_rd = clt_pkg::classify(rdata_q, quote_q, delete_q, end_q);

	// token split of one stored character
	always_comb begin
		emit       = 1'b0;
		close      = 1'b0;
		quoted_nxt = quoted_q;
		if (quoted_q) begin
			emit = 1'b1;
			if (cls_rd == clt_pkg::CLS_QUOTE) begin
				close      = 1'b1;
				quoted_nxt = 1'b0;
			end
		end else if (cls_rd == clt_pkg::CLS_DELIM) begin
			close = 1'b1;
		end else begin
			emit = 1'b1;
			if (cls_rd == clt_pkg::CLS_QUOTE) begin
				quoted_nxt = 1'b1;
			end
		end
	end

	assign can_push   = !ovalid_q || out_ready;
	assign proc_stall = emit && pend_valid_q && !can_push;
	assign proc_go    = cmd.proc && !proc_stall;
	assign push_proc  = proc_go && emit && pend_valid_q;
	assign push_flush = cmd.flush && pend_valid_q && can_push;

	assign has_room = fill_q < clt_pkg::FILL_W'(clt_pkg::LINE_CHARS);
	assign we       = cmd.wr_en && has_room;
	assign wdata    = cmd.wr_space ? clt_pkg::SPACE_CHAR : char_q;

	assign sts.cls        = cls_in;
	assign sts.mode       = mode_q;
	assign sts.scan_end   = idx_q == fill_q;
	assign sts.proc_stall = proc_stall;
	assign sts.flush_wait = pend_valid_q && !can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delete_q <= clt_pkg::DELETE_RST;
			end_q    <= clt_pkg::END_RST;
			quote_q  <= clt_pkg::QUOTE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				clt_pkg::REG_DELETE_CODE: delete_q <= cfg_wdata;
				clt_pkg::REG_END_CODE:    end_q    <= cfg_wdata;
				clt_pkg::REG_QUOTE_CODE:  quote_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= clt_pkg::MODE_BETWEEN;
			fill_q       <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_tlast_q <= 1'b0;
			open_q       <= 1'b0;
			quoted_q     <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cmd.step_mode) begin
				mode_q <= clt_pkg::next_mode(cls_in, mode_q);
			end

			if (cmd.line_done) begin
				fill_q <= '0;
			end else if (we) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.del && fill_q != '0) begin
				fill_q <= fill_q - 1'b1;
			end

			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.rd) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.scan_start) begin
				pend_valid_q <= 1'b0;
				pend_tlast_q <= 1'b0;
				open_q       <= 1'b0;
				quoted_q     <= 1'b0;
			end else if (proc_go) begin
				quoted_q <= quoted_nxt;
				if (emit) begin
					pend_valid_q <= 1'b1;
					pend_tlast_q <= close;
					open_q       <= !close;
				end else if (close) begin
					if (open_q) begin
						pend_tlast_q <= 1'b1;
					end
					open_q <= 1'b0;
				end
			end else if (push_flush) begin
				pend_valid_q <= 1'b0;
			end

			if (push_proc || push_flush) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			char_q <= char_code;
		end
		if (proc_go && emit) begin
			pend_char_q <= rdata_q;
		end
		if (push_proc) begin
			ochar_q  <= pend_char_q;
			otlast_q <= pend_tlast_q;
			ollast_q <= 1'b0;
		end else if (push_flush) begin
			ochar_q  <= pend_char_q;
			otlast_q <= 1'b1;
			ollast_q <= 1'b1;
		end
	end

	// line store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[fill_q[clt_pkg::ADDR_W-1:0]] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q[clt_pkg::ADDR_W-1:0]];
		end
	end

	assign out_valid = ovalid_q;
	assign out_char  = ochar_q;
	assign out_tlast = otlast_q;
	assign out_llast = ollast_q;

endmodule

`default_nettype wire

// ===== rtl/clt_controller.sv =====
// controller state machine: editing steps and line scan sequencing
`timescale 1ns / 1ps
`default_nettype none

module clt_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire clt_pkg::sts_t sts,
	output      clt_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_EXEC     = 7'b0000010,
		S_WR_SPACE = 7'b0000100,
		S_WR_CHAR  = 7'b0001000,
		S_RD       = 7'b0010000,
		S_PROC     = 7'b0100000,
		S_FLUSH    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.step_mode = 1'b1;
				state_nxt     = S_IDLE;
				case (sts.cls)
					clt_pkg::CLS_DELIM: begin
						cmd.wr_en = sts.mode == clt_pkg::MODE_QUOTED ||
							sts.mode == clt_pkg::MODE_WORD;
					end
					clt_pkg::CLS_QUOTE: begin
						cmd.wr_en = 1'b1;
						// closing quote gets a space after, a quote inside a word one before
						if (sts.mode == clt_pkg::MODE_QUOTED) begin
							state_nxt = S_WR_SPACE;
						end else if (sts.mode == clt_pkg::MODE_WORD) begin
							cmd.wr_space = 1'b1;
							state_nxt    = S_WR_CHAR;
						end
					end
					clt_pkg::CLS_DELETE: begin
						cmd.del = 1'b1;
					end
					clt_pkg::CLS_END: begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_RD;
					end
					default: begin
						cmd.wr_en = 1'b1;
					end
				endcase
			end
			S_WR_SPACE: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_space = 1'b1;
				state_nxt    = S_IDLE;
			end
			S_WR_CHAR: begin
				cmd.wr_en = 1'b1;
				state_nxt = S_IDLE;
			end
			S_RD: begin
				if (sts.scan_end) begin
					state_nxt = S_FLUSH;
				end else begin
					cmd.rd    = 1'b1;
					state_nxt = S_PROC;
				end
			end
			S_PROC: begin
				cmd.proc = 1'b1;
				if (!sts.proc_stall) begin
					state_nxt = S_RD;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				if (!sts.flush_wait) begin
					cmd.line_done = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/clt_checker.sv =====
// port-level checks of the console line tokenizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module clt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] token_char,
	input wire logic       token_last,
	input wire logic       line_last
);

	// a stalled output transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_char) &&
			$stable(token_last) && $stable(line_last))
		else $error("output payload changed while stalled");

	// the last character of a line always closes a token
	a_line_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_last |-> token_last)
		else $error("line_last without token_last");

	// each character needs an execute step before the next is taken
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind console_line_tokenizer_unit clt_checker u_clt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (char_in.valid),
	.in_ready   (char_in.ready),
	.out_valid  (tok_out.valid),
	.out_ready  (tok_out.ready),
	.token_char (tok_out.token_char),
	.token_last (tok_out.token_last),
	.line_last  (tok_out.line_last)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench of the console line tokenizer: directed and random lines checked against a predictor
`timescale 1ns / 1ps

module tb_top;
	import clt_pkg::*;

	localparam int SETTLE_CYCLES = 2 * LINE_CHARS + 8;
	localparam int LONG_GAP      = 60;
	localparam int CYCLE_LIMIT   = 3 * 450 *
		(LONG_GAP + 3 + LINE_CHARS * (LONG_GAP + 2) + SETTLE_CYCLES);

	typedef struct packed {
		logic [7:0] token_char;
		logic       token_last;
		logic       line_last;
	} token_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	clt_char_if char_in ();
	clt_tok_if  tok_out ();
	clt_cfg_if  cfg ();

	console_line_tokenizer_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.tok_out (tok_out),
		.cfg     (cfg)
	);

	// predictor state
	token_beat_t token_chars_due[$];
	logic [7:0]  delete_code_m = DELETE_RST;
	logic [7:0]  end_code_m    = END_RST;
	logic [7:0]  quote_code_m  = QUOTE_RST;
	mode_t       parse_mode_m  = MODE_BETWEEN;
	logic [7:0]  line_m [LINE_CHARS];
	int          fill_m        = 0;

	int errors      = 0;
	int items_sent  = 0;
	int cycles      = 0;
	bit smooth_flow = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cls_t char_class(input logic [7:0] c);
		if (c == COMMA_CHAR || c == SPACE_CHAR || c == COLON_CHAR || c == SLASH_CHAR)
			return CLS_DELIM;
		if (c == quote_code_m)
			return CLS_QUOTE;
		if (c == delete_code_m)
			return CLS_DELETE;
		if (c == end_code_m)
			return CLS_END;
		return CLS_OTHER;
	endfunction

	function automatic mode_t mode_after(input cls_t k, input mode_t m);
		case (k)
			CLS_DELIM: begin
				if (m == MODE_QUOTED || m == MODE_BETWEEN)
					return m;
				return MODE_AFTER;
			end
			CLS_QUOTE:  return (m == MODE_QUOTED) ? MODE_AFTER : MODE_QUOTED;
			CLS_DELETE: return m;
			CLS_END:    return MODE_BETWEEN;
			default:    return (m == MODE_QUOTED) ? MODE_QUOTED : MODE_WORD;
		endcase
	endfunction

	function automatic void store_m(input logic [7:0] c);
		if (fill_m < LINE_CHARS) begin
			line_m[fill_m] = c;
			fill_m++;
		end
	endfunction

	// split the stored line into tokens and queue their characters
	function automatic void split_line();
		token_beat_t beats [LINE_CHARS];
		int          n;
		int          i;
		bit          open_tok;
		bit          in_quote;
		bit          emit;
		bit          close;
		cls_t        k;
		n = 0;
		open_tok = 1'b0;
		in_quote = 1'b0;
		for (i = 0; i < fill_m; i++) begin
			k = char_class(line_m[i]);
			emit = 1'b0;
			close = 1'b0;
			if (in_quote) begin
				emit = 1'b1;
				if (k == CLS_QUOTE) begin
					in_quote = 1'b0;
					close = 1'b1;
				end
			end else if (k == CLS_DELIM) begin
				close = 1'b1;
			end else begin
				emit = 1'b1;
				if (k == CLS_QUOTE)
					in_quote = 1'b1;
			end
			if (emit) begin
				beats[n] = {line_m[i], 1'b0, 1'b0};
				n++;
				open_tok = 1'b1;
			end
			if (close && open_tok) begin
				beats[n-1].token_last = 1'b1;
				open_tok = 1'b0;
			end
		end
		if (open_tok)
			beats[n-1].token_last = 1'b1;
		if (n > 0)
			beats[n-1].line_last = 1'b1;
		for (i = 0; i < n; i++)
			token_chars_due.push_back(beats[i]);
	endfunction

	function automatic void apply_char(input logic [7:0] c);
		cls_t  k;
		mode_t m;
		k = char_class(c);
		m = parse_mode_m;
		case (k)
			CLS_DELIM: begin
				if (m == MODE_QUOTED || m == MODE_WORD)
					store_m(c);
			end
			CLS_QUOTE: begin
				if (m == MODE_QUOTED) begin
					store_m(c);
					store_m(SPACE_CHAR);
				end else if (m == MODE_WORD) begin
					store_m(SPACE_CHAR);
					store_m(c);
				end else begin
					store_m(c);
				end
			end
			CLS_DELETE: begin
				if (fill_m > 0)
					fill_m--;
			end
			CLS_END: begin
				split_line();
				fill_m = 0;
			end
			default: store_m(c);
		endcase
		parse_mode_m = mode_after(k, m);
	endfunction

	always @(posedge clk) begin
		if (arst_n && char_in.valid && char_in.ready)
			apply_char(char_in.char_code);
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DELETE_CODE: delete_code_m = cfg.wdata;
				REG_END_CODE:    end_code_m = cfg.wdata;
				REG_QUOTE_CODE:  quote_code_m = cfg.wdata;
				default: ;
			endcase
		end
	end

	task automatic mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		errors++;
		if (errors <= 100)
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_tokens
		token_beat_t want;
		if (arst_n && tok_out.valid && tok_out.ready) begin
			if (token_chars_due.size() == 0) begin
				mismatch("token_char (no transaction due)", 8'h00, tok_out.token_char);
			end else begin
				want = token_chars_due.pop_front();
				if (tok_out.token_char !== want.token_char)
					mismatch("token_char", want.token_char, tok_out.token_char);
				if (tok_out.token_last !== want.token_last)
					mismatch("token_last", want.token_last, tok_out.token_last);
				if (tok_out.line_last !== want.line_last)
					mismatch("line_last", want.line_last, tok_out.line_last);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		if (smooth_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, LONG_GAP);
	endfunction

	initial begin : sink_stall
		int g;
		tok_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = idle_len();
			if (g == 0) begin
				tok_out.ready <= 1'b1;
			end else begin
				tok_out.ready <= 1'b0;
				repeat (g) @(posedge clk);
				tok_out.ready <= 1'b1;
			end
		end
	end

	task automatic send_char(input logic [7:0] c);
		int g;
		char_in.valid <= 1'b1;
		char_in.char_code <= c;
		do @(posedge clk); while (!char_in.ready);
		items_sent++;
		g = idle_len();
		if (g > 0) begin
			char_in.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// let every due token character arrive and the scan of trailing delimiters finish
	task automatic wait_idle();
		char_in.valid <= 1'b0;
		@(posedge clk);
		while (token_chars_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_codes(input logic [7:0] del_c, input logic [7:0] end_c,
			input logic [7:0] quote_c);
		wait_idle();
		put_reg(REG_DELETE_CODE, del_c);
		put_reg(REG_END_CODE, end_c);
		put_reg(REG_QUOTE_CODE, quote_c);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = $urandom_range(0, 255); while (char_class(c) != CLS_OTHER);
		return c;
	endfunction

	function automatic logic [7:0] delim_char();
		case ($urandom_range(0, 3))
			0:       return COMMA_CHAR;
			1:       return SPACE_CHAR;
			2:       return COLON_CHAR;
			default: return SLASH_CHAR;
		endcase
	endfunction

	// one line of words, quoted parts and delimiter runs, closed by the end code
	task automatic send_rand_line();
		int words;
		int wl;
		int w;
		int i;
		bit quoted;
		bit has_quote;
		bit has_delete;
		has_quote = (char_class(quote_code_m) == CLS_QUOTE);
		has_delete = (char_class(delete_code_m) == CLS_DELETE);
		words = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_char(delim_char());
		for (w = 0; w < words; w++) begin
			quoted = has_quote && ($urandom_range(0, 3) == 0);
			if (quoted)
				send_char(quote_code_m);
			wl = $urandom_range(1, 7);
			for (i = 0; i < wl; i++) begin
				case ($urandom_range(0, 9))
					0:       send_char(has_delete ? delete_code_m : plain_char());
					1:       send_char(quoted ? delim_char() : plain_char());
					default: send_char(plain_char());
				endcase
			end
			if (quoted) begin
				// sometimes left open up to the end of the line
				if ($urandom_range(0, 5) != 0)
					send_char(quote_code_m);
			end else if (has_quote && $urandom_range(0, 7) == 0) begin
				send_char(quote_code_m);
				send_char(plain_char());
				send_char(quote_code_m);
			end
			repeat ($urandom_range(0, 2)) send_char(delim_char());
		end
		send_char(end_code_m);
	endtask

	task automatic run_random(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6)) send_char($urandom_range(0, 255));
			else
				send_rand_line();
		end
		send_char(end_code_m);
	endtask

	task automatic test_directed();
		// extreme bytes, then a run of delimiters collapsed to one split
		send_char(8'h00);
		send_char(8'hff);
		send_text(",, b");
		send_char(end_code_m);
		// delete on an empty line, then a line with nothing to send
		send_char(delete_code_m);
		send_char(end_code_m);
		// quote inside a word, delimiters inside quotes, a token after the closing quote deleted,
		// then a quote left open at the end of the line
		send_text("a\"x :\"q");
		send_char(delete_code_m);
		send_text("/\"z");
		send_char(end_code_m);
	endtask

	task automatic test_full_line();
		repeat (LINE_CHARS + 6) send_char("k");
		send_char(end_code_m);
		// only the space of the space/quote pair fits
		repeat (LINE_CHARS - 1) send_char("k");
		send_char(quote_code_m);
		send_char("m");
		send_char(end_code_m);
	endtask

	task automatic test_code_roles();
		// quote on a delimiter and end equal to delete both lose their role
		set_codes(8'h22, 8'h22, COMMA_CHAR);
		send_text("a\"b,c");
		set_codes(8'h22, 8'h0a, COMMA_CHAR);
		send_char(8'h0a);
	endtask

	task automatic test_random_lines();
		set_codes(DELETE_RST, END_RST, QUOTE_RST);
		run_random(45);
		set_codes(8'h00, 8'hff, QUOTE_RST);
		run_random(40);
		smooth_flow = 1'b1;
		set_codes(8'h80, 8'h00, 8'hff);
		run_random(40);
		smooth_flow = 1'b0;
		set_codes(8'h08, 8'h0a, 8'h27);
		run_random(40);
	endtask

	initial begin
		arst_n <= 1'b0;
		char_in.valid <= 1'b0;
		char_in.char_code <= 8'h00;
		cfg.valid <= 1'b0;
		cfg.index <= REG_DELETE_CODE;
		cfg.wdata <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_line();
		test_code_roles();
		test_random_lines();
		wait_idle();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== console_line_tokenizer_unit.f =====
rtl/clt_pkg.sv
rtl/clt_char_if.sv
rtl/clt_tok_if.sv
rtl/clt_cfg_if.sv
rtl/clt_datapath.sv
rtl/clt_controller.sv
rtl/console_line_tokenizer_unit.sv
rtl/clt_checker.sv
tb/sv/tb_top.sv
